>>> rtl/core/qidtt_pkg.sv
// Package for the query identifier translation table core.
// Holds the table geometry, command codes and slot/result record types.
// Depends on nothing; imported by query_id_translation_table_core.
package qidtt_pkg;

    localparam int TABLE_DEPTH    = 1024;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int SLOT_W         = 10;
    localparam int ID_W           = 16;
    localparam int IP_W           = 32;
    localparam int PORT_W         = 16;
    localparam int SEC_W          = 32;
    localparam int LIFE_W         = 16;
    localparam int CMD_W          = 2;
    localparam int S_DATA_W       = 80;
    localparam int M_DATA_W       = 80;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(10);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Per-slot bookkeeping: in-use flag and the second after which it lapses.
    typedef struct packed {
        logic             used;
        logic [SEC_W-1:0] expiry;
    } slot_meta_t;

    // Per-slot client record.
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   ip;
        logic [ID_W-1:0]   id;
    } slot_data_t;

    typedef struct packed {
        logic              full;
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   ip;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] relay;
    } result_t;

endpackage

>>> rtl/core/query_id_translation_table_core.sv
// Top level of the query identifier translation table.
// Holds the slot memories, the allocation scanner and the stream handshakes.
// Depends on qidtt_pkg.

// The core hands out relay identifiers for forwarded queries. An allocate word
// scans the slots from 0 upward and takes the first one that is unused or whose
// expiry second lies strictly below the seconds counter; it records the client
// identifier, address, port and an expiry of now plus the configured lifetime
// (saturating), and returns the slot index. If no slot is free the result word
// carries the full flag and zero fields. A lookup word returns the fields held
// in one slot, and a tick word advances the saturating seconds counter. One word
// is worked on at a time. The scan reads one slot per cycle from the bookkeeping
// memory, so an allocate presents its result once the scan stops at a free slot
// or has checked the last one; a lookup passes through the read and data states,
// and a tick or an unused command goes straight to the hand-off state. The next
// input word is accepted in the cycle after a result has been loaded. A new input
// word is accepted even while the previous result still waits in the output
// register; a finished result waits in the hand-off state for as long as the
// output register holds a word that has not been taken. After reset the core
// clears the in-use flag of every slot and accepts no word during that pass;
// lifetime writes are taken at any time.
module query_id_translation_table_core
    import qidtt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wen,
    input  logic [LIFE_W-1:0]    cfg_wdata,    // lifetime_seconds

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // orig_id[15:0], client_ip[47:16], client_port[63:48], slot_index[73:64]
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,      // cmd[1:0]

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // relay_id[9:0], stored_id[25:10], stored_ip[57:26], stored_port[73:58]
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tuser       // table_full[0]
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LREAD,
        ST_LDATA,
        ST_PUSH
    } state_t;

    state_t             state_reg;
    logic [LIFE_W-1:0]  lifetime_reg;
    logic [SEC_W-1:0]   seconds_reg;

    // Captured input word.
    cmd_t               cmd_in;
    slot_data_t         item_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SEC_W-1:0]   exp_reg;

    // Scan pipeline: address being read and the address whose data is back.
    logic [ADDR_W-1:0]  scan_addr_reg;
    logic [ADDR_W-1:0]  chk_addr_reg;
    logic               chk_valid_reg;

    result_t            res_reg;
    result_t            out_reg;
    logic               out_valid_reg;

    // Memories with registered read ports.
    slot_meta_t         meta_mem [TABLE_DEPTH];
    slot_data_t         data_mem [TABLE_DEPTH];
    slot_meta_t         meta_q;
    slot_data_t         data_q;

    logic               meta_we;
    logic [ADDR_W-1:0]  meta_waddr;
    slot_meta_t         meta_wdata;
    logic               data_we;
    logic               slot_free;
    logic [SEC_W:0]     exp_sum;
    logic [SEC_W-1:0]   exp_next;
    logic               accept;

    assign cmd_in   = cmd_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Expiry for a slot allocated now, saturating at the top of the counter.
    assign exp_sum  = {1'b0, seconds_reg} + (SEC_W+1)'(lifetime_reg);
    assign exp_next = exp_sum[SEC_W] ? {SEC_W{1'b1}} : exp_sum[SEC_W-1:0];

    // A slot is free when it was never taken or its expiry second has passed.
    assign slot_free = !meta_q.used || (meta_q.expiry < seconds_reg);

    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = chk_addr_reg;
        meta_wdata = '{used: 1'b1, expiry: exp_reg};
        data_we    = 1'b0;
        if (state_reg == ST_CLEAR) begin
            meta_we    = 1'b1;
            meta_waddr = scan_addr_reg;
            meta_wdata = '0;
        end else if (state_reg == ST_SCAN && chk_valid_reg && slot_free) begin
            meta_we = 1'b1;
            data_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_q <= meta_mem[scan_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[chk_addr_reg] <= item_reg;
        end
        data_q <= data_mem[slot_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lifetime_reg <= LIFETIME_RESET;
        end else if (cfg_wen) begin
            lifetime_reg <= cfg_wdata;
        end
    end

    // Control state machine and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            seconds_reg   <= '0;
            scan_addr_reg <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // The hand-off state reloads the output register itself.
            if (out_valid_reg && m_tready && state_reg != ST_PUSH) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
                    if (scan_addr_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        item_reg.id   <= s_tdata[15:0];
                        item_reg.ip   <= s_tdata[47:16];
                        item_reg.port <= s_tdata[63:48];
                        slot_reg      <= s_tdata[73:64];
                        exp_reg       <= exp_next;
                        res_reg       <= '0;
                        scan_addr_reg <= '0;
                        chk_valid_reg <= 1'b0;
                        unique case (cmd_in)
                            CMD_ALLOC:  state_reg <= ST_SCAN;
                            CMD_LOOKUP: state_reg <= ST_LREAD;
                            CMD_TICK: begin
                                if (seconds_reg != {SEC_W{1'b1}}) begin
                                    seconds_reg <= seconds_reg + SEC_W'(1);
                                end
                                state_reg <= ST_PUSH;
                            end
                            CMD_NONE:   state_reg <= ST_PUSH;
                            default:    state_reg <= ST_PUSH;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (chk_valid_reg && slot_free) begin
                        res_reg.full  <= 1'b0;
                        res_reg.relay <= SLOT_W'(chk_addr_reg);
                        res_reg.id    <= item_reg.id;
                        res_reg.ip    <= item_reg.ip;
                        res_reg.port  <= item_reg.port;
                        state_reg     <= ST_PUSH;
                    end else if (chk_valid_reg &&
                                 chk_addr_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                        res_reg   <= '{full: 1'b1, default: '0};
                        state_reg <= ST_PUSH;
                    end else begin
                        chk_addr_reg  <= scan_addr_reg;
                        chk_valid_reg <= 1'b1;
                        scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
                    end
                end
                ST_LREAD: begin
                    state_reg <= ST_LDATA;
                end
                ST_LDATA: begin
                    res_reg.full  <= 1'b0;
                    res_reg.relay <= slot_reg;
                    res_reg.id    <= data_q.id;
                    res_reg.ip    <= data_q.ip;
                    res_reg.port  <= data_q.port;
                    state_reg     <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!out_valid_reg || m_tready) begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.full;
    assign m_tdata  = {6'd0, out_reg.port, out_reg.ip, out_reg.id, out_reg.relay};

    // An allocation only ever overwrites a slot that is free at that moment.
    a_alloc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (data_we |-> (!meta_q.used || meta_q.expiry < seconds_reg)))
        else $error("allocation overwrote a live slot");

    // The seconds counter never moves backward.
    a_seconds_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) |-> seconds_reg >= $past(seconds_reg)))
        else $error("seconds counter went backward");

    // A fresh result word is only loaded from the hand-off state.
    a_out_from_push: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid) |-> $past(state_reg == ST_PUSH)))
        else $error("result word appeared outside the hand-off state");

    // A full-table answer carries zero fields.
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((m_tvalid && m_tuser) |-> (m_tdata == '0)))
        else $error("full-table result carries nonzero fields");

endmodule
